>>> sv/csds_pkg.sv
// Shared widths, reset values and register indexes of the divider search block.
package csds_pkg;

  localparam int CRYSTAL_W  = 27;
  localparam int FREQ_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MULT_OUT_W = 6;
  localparam int DIV_OUT_W  = 7;
  localparam int P1_W       = 18;
  localparam int P1_SHIFT   = 7;
  localparam int P1_OFFSET  = 512;
  localparam int DIV_MIN    = 6;

  localparam int MULT_FIRST_DEF = 25;
  localparam int MULT_LAST_DEF  = 36;
  localparam int DIV_MAX_DEF    = 127;

  localparam logic [CRYSTAL_W-1:0] CRYSTAL_RST = 27'd25000000;
  localparam logic [FREQ_W-1:0]    VCO_MIN_RST = 32'd600000000;
  localparam logic [FREQ_W-1:0]    VCO_MAX_RST = 32'd900000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRYSTAL = 2'd0,
    CFG_VCO_MIN = 2'd1,
    CFG_VCO_MAX = 2'd2
  } cfg_idx_t;

endpackage

>>> sv/clock_synth_divider_search_top.sv
// Top level of the integer-mode clock synthesizer multiplier and divider search.
// Takes one target frequency per clock (busy stays low) and returns one result beat per
// target, in order. The pipeline holds QW = clog2(DIV_MAX + 3) steps of the ideal-divider
// chain, VW = clog2(MULT_LAST + 1) + 27 steps of the achieved-frequency chains, and
// LV = clog2(MULT_LAST - MULT_FIRST + 1) levels of the best-pair tree. Each multiplier
// has its own lane of division cells, so a new target enters every cycle. The result
// strobe out_valid lasts one cycle and cannot be held off. Configuration writes are
// taken at once and may only be issued
// while no target is in flight.
module clock_synth_divider_search_top #(
  parameter int MULT_FIRST = csds_pkg::MULT_FIRST_DEF,
  parameter int MULT_LAST  = csds_pkg::MULT_LAST_DEF,
  parameter int DIV_MAX    = csds_pkg::DIV_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [csds_pkg::FREQ_W-1:0]     in_target_freq_hz,
  input  logic                            cfg_we,
  input  logic [csds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csds_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  output logic                            out_found,
  output logic [csds_pkg::MULT_OUT_W-1:0] out_pll_mult,
  output logic [csds_pkg::DIV_OUT_W-1:0]  out_out_div,
  output logic [csds_pkg::FREQ_W-1:0]     out_achieved_freq_hz,
  output logic [csds_pkg::FREQ_W-1:0]     out_freq_error_hz,
  output logic [csds_pkg::P1_W-1:0]       out_pll_p1_word,
  output logic [csds_pkg::P1_W-1:0]       out_div_p1_word
);

  localparam int FW   = csds_pkg::FREQ_W;
  localparam int CW   = csds_pkg::CRYSTAL_W;
  localparam int P1W  = csds_pkg::P1_W;
  localparam int MOW  = csds_pkg::MULT_OUT_W;
  localparam int DOW  = csds_pkg::DIV_OUT_W;
  localparam int NL   = MULT_LAST - MULT_FIRST + 1;
  localparam int NW   = $clog2(MULT_LAST + 1);
  localparam int VW   = NW + CW;
  localparam int QW   = $clog2(DIV_MAX + 3);
  localparam int MW   = QW + 1;
  localparam int XW   = (VW > FW) ? VW : FW;
  localparam int OW   = (VW > FW + QW) ? VW : FW + QW;
  localparam int LV   = $clog2(NL);
  localparam int PL   = 1 << LV;
  localparam int D    = QW + VW;
  localparam int LAT  = D + LV + 4;

  logic [CW-1:0] crystal_r;
  logic [FW-1:0] vco_min_r;
  logic [FW-1:0] vco_max_r;

  logic [VW-1:0] vco_r [NL];
  logic          vld_r [D+1];
  logic [FW-1:0] tgt_r [D+1];
  logic          iv_e1_r;
  logic          iv_r  [LV+1];

  logic [FW-1:0] m0_rem [NL][QW+1];
  logic [FW-1:0] m0_dvs [NL][QW+1];
  logic [QW-1:0] m0_dq  [NL][QW+1];
  logic          skip_r [NL][QW];

  logic [MW-1:0] fc_rem [NL][3][VW+1];
  logic [MW-1:0] fc_dvs [NL][3][VW+1];
  logic [VW-1:0] fc_dq  [NL][3][VW+1];

  logic          e1_vld_r [NL][3];
  logic [MW-1:0] e1_m_r   [NL][3];
  logic [VW-1:0] e1_f_r   [NL][3];
  logic [XW-1:0] e1_e_r   [NL][3];

  logic          t_vld [LV+1][PL];
  logic [NW-1:0] t_n   [LV+1][PL];
  logic [MW-1:0] t_m   [LV+1][PL];
  logic [VW-1:0] t_f   [LV+1][PL];
  logic [XW-1:0] t_e   [LV+1][PL];

  logic           out_valid_r;
  logic           found_r;
  logic [MOW-1:0] mult_r;
  logic [DOW-1:0] div_r;
  logic [FW-1:0]  ach_r;
  logic [FW-1:0]  err_r;
  logic [P1W-1:0] pll_p1_r;
  logic [P1W-1:0] div_p1_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crystal_r <= csds_pkg::CRYSTAL_RST;
      vco_min_r <= csds_pkg::VCO_MIN_RST;
      vco_max_r <= csds_pkg::VCO_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csds_pkg::CFG_CRYSTAL: crystal_r <= cfg_data[CW-1:0];
        csds_pkg::CFG_VCO_MIN: vco_min_r <= cfg_data[FW-1:0];
        csds_pkg::CFG_VCO_MAX: vco_max_r <= cfg_data[FW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= D; k++) begin
        vld_r[k] <= 1'b0;
      end
      iv_e1_r <= 1'b0;
      for (int k = 0; k <= LV; k++) begin
        iv_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= start && !busy;
      for (int k = 1; k <= D; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      iv_e1_r <= vld_r[D];
      iv_r[0] <= iv_e1_r;
      for (int k = 1; k <= LV; k++) begin
        iv_r[k] <= iv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt_r[0] <= in_target_freq_hz;
    for (int k = 1; k <= D; k++) begin
      tgt_r[k] <= tgt_r[k-1];
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    localparam logic [NW-1:0] N_VAL = NW'(MULT_FIRST + l);

    logic          win;
    logic          ovf;
    logic [QW-1:0] m0e;
    logic [MW-1:0] cand [3];
    logic          cand_ok [3];
    logic          b_v;
    logic [MW-1:0] b_m;
    logic [VW-1:0] b_f;
    logic [XW-1:0] b_e;

    always_ff @(posedge clk) begin
      vco_r[l] <= VW'(N_VAL) * VW'(crystal_r);
    end

    always_comb begin
      win = (XW'(vco_r[l]) >= XW'(vco_min_r)) && (XW'(vco_r[l]) <= XW'(vco_max_r));
      ovf = OW'(vco_r[l]) >= (OW'(tgt_r[0]) << QW);
    end

    assign m0_rem[l][0] = FW'(OW'(vco_r[l]) >> QW);
    assign m0_dq[l][0]  = vco_r[l][QW-1:0];
    assign m0_dvs[l][0] = tgt_r[0];

    always_ff @(posedge clk) begin
      skip_r[l][0] <= ovf || !win;
      for (int k = 1; k < QW; k++) begin
        skip_r[l][k] <= skip_r[l][k-1];
      end
    end

    for (genvar c = 0; c < QW; c++) begin : g_m0
      csds_div_cell #(.REM_W(FW), .DQ_W(QW)) u_cell (
        .clk   (clk),
        .rem_i (m0_rem[l][c]),
        .dvs_i (m0_dvs[l][c]),
        .dq_i  (m0_dq[l][c]),
        .rem_r (m0_rem[l][c+1]),
        .dvs_r (m0_dvs[l][c+1]),
        .dq_r  (m0_dq[l][c+1])
      );
    end

    always_comb begin
      m0e        = {m0_dq[l][QW][QW-1:1], 1'b0};
      cand[1]    = MW'(m0e);
      cand[0]    = cand[1] - MW'(2);
      cand[2]    = cand[1] + MW'(2);
      for (int k = 0; k < 3; k++) begin
        cand_ok[k] = !skip_r[l][QW-1] && (cand[k] >= MW'(csds_pkg::DIV_MIN)) &&
                     (cand[k] <= MW'(DIV_MAX));
      end
      cand_ok[0] = cand_ok[0] && (cand[1] >= MW'(2));
    end

    for (genvar k = 0; k < 3; k++) begin : g_cand
      assign fc_rem[l][k][0] = '0;
      assign fc_dvs[l][k][0] = cand_ok[k] ? cand[k] : '0;
      assign fc_dq[l][k][0]  = vco_r[l];

      for (genvar c = 0; c < VW; c++) begin : g_f
        csds_div_cell #(.REM_W(MW), .DQ_W(VW)) u_cell (
          .clk   (clk),
          .rem_i (fc_rem[l][k][c]),
          .dvs_i (fc_dvs[l][k][c]),
          .dq_i  (fc_dq[l][k][c]),
          .rem_r (fc_rem[l][k][c+1]),
          .dvs_r (fc_dvs[l][k][c+1]),
          .dq_r  (fc_dq[l][k][c+1])
        );
      end

      always_ff @(posedge clk) begin
        e1_vld_r[l][k] <= fc_dvs[l][k][VW] != '0;
        e1_m_r[l][k]   <= fc_dvs[l][k][VW];
        e1_f_r[l][k]   <= fc_dq[l][k][VW];
        e1_e_r[l][k]   <= (XW'(fc_dq[l][k][VW]) >= XW'(tgt_r[D])) ?
                          XW'(fc_dq[l][k][VW]) - XW'(tgt_r[D]) :
                          XW'(tgt_r[D]) - XW'(fc_dq[l][k][VW]);
      end
    end

    always_comb begin
      b_v = e1_vld_r[l][0];
      b_m = e1_m_r[l][0];
      b_f = e1_f_r[l][0];
      b_e = e1_e_r[l][0];
      for (int k = 1; k < 3; k++) begin
        if (e1_vld_r[l][k] && (!b_v || (e1_e_r[l][k] < b_e))) begin
          b_v = 1'b1;
          b_m = e1_m_r[l][k];
          b_f = e1_f_r[l][k];
          b_e = e1_e_r[l][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        t_vld[0][l] <= 1'b0;
      end else begin
        t_vld[0][l] <= b_v;
      end
      t_n[0][l] <= N_VAL;
      t_m[0][l] <= b_m;
      t_f[0][l] <= b_f;
      t_e[0][l] <= b_e;
    end
  end

  for (genvar l = NL; l < PL; l++) begin : g_pad
    assign t_vld[0][l] = 1'b0;
    assign t_n[0][l]   = '0;
    assign t_m[0][l]   = '0;
    assign t_f[0][l]   = '0;
    assign t_e[0][l]   = '0;
  end

  for (genvar k = 0; k < LV; k++) begin : g_lvl
    for (genvar i = 0; i < (PL >> (k + 1)); i++) begin : g_node
      logic take;

      assign take = t_vld[k][2*i+1] &&
                    (!t_vld[k][2*i] || (t_e[k][2*i+1] < t_e[k][2*i]));

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          t_vld[k+1][i] <= 1'b0;
        end else begin
          t_vld[k+1][i] <= t_vld[k][2*i] || t_vld[k][2*i+1];
        end
        t_n[k+1][i] <= take ? t_n[k][2*i+1] : t_n[k][2*i];
        t_m[k+1][i] <= take ? t_m[k][2*i+1] : t_m[k][2*i];
        t_f[k+1][i] <= take ? t_f[k][2*i+1] : t_f[k][2*i];
        t_e[k+1][i] <= take ? t_e[k][2*i+1] : t_e[k][2*i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= iv_r[LV];
    end
    found_r <= t_vld[LV][0];
    if (t_vld[LV][0]) begin
      mult_r   <= MOW'(t_n[LV][0]);
      div_r    <= DOW'(t_m[LV][0]);
      ach_r    <= FW'(t_f[LV][0]);
      err_r    <= FW'(t_e[LV][0]);
      pll_p1_r <= (P1W'(t_n[LV][0]) << csds_pkg::P1_SHIFT) - P1W'(csds_pkg::P1_OFFSET);
      div_p1_r <= (P1W'(t_m[LV][0]) << csds_pkg::P1_SHIFT) - P1W'(csds_pkg::P1_OFFSET);
    end else begin
      mult_r   <= '0;
      div_r    <= '0;
      ach_r    <= '0;
      err_r    <= '0;
      pll_p1_r <= '0;
      div_p1_r <= '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_found            = found_r;
  assign out_pll_mult         = mult_r;
  assign out_out_div          = div_r;
  assign out_achieved_freq_hz = ach_r;
  assign out_freq_error_hz    = err_r;
  assign out_pll_p1_word      = pll_p1_r;
  assign out_div_p1_word      = div_p1_r;

`ifndef SYNTH
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("result beat missing at fixed latency");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_pll_mult == '0 && out_out_div == '0 &&
      out_achieved_freq_hz == '0 && out_freq_error_hz == '0 &&
      out_pll_p1_word == '0 && out_div_p1_word == '0)
    else $error("not-found beat carries nonzero fields");

  a_even_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> !out_out_div[0])
    else $error("odd output divider chosen");
`endif

endmodule

>>> sv/csds_div_cell.sv
// One restoring long-division step: shift in a dividend bit, subtract if it fits, shift in a quotient bit.
module csds_div_cell #(
  parameter int REM_W = 8,
  parameter int DQ_W  = 8
) (
  input  logic             clk,
  input  logic [REM_W-1:0] rem_i,
  input  logic [REM_W-1:0] dvs_i,
  input  logic [DQ_W-1:0]  dq_i,
  output logic [REM_W-1:0] rem_r,
  output logic [REM_W-1:0] dvs_r,
  output logic [DQ_W-1:0]  dq_r
);

  logic [REM_W:0]   trial;
  logic             ge;
  logic [REM_W-1:0] rem_nxt;
  logic [DQ_W-1:0]  dq_nxt;

  always_comb begin
    trial   = {rem_i, dq_i[DQ_W-1]};
    ge      = trial >= {1'b0, dvs_i};
    rem_nxt = ge ? REM_W'(trial - {1'b0, dvs_i}) : trial[REM_W-1:0];
    dq_nxt  = {dq_i[DQ_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_i;
    dq_r  <= dq_nxt;
  end

endmodule
